// ----- hdl/brte_pkg.sv -----
// Package for the battery remaining-time estimator.
// Holds field widths, the request and response item types and the sequencer states.
// Has no dependencies of its own.
package brte_pkg;

  localparam int CAP_W    = 24;             // capacity and power width
  localparam int TIME_W   = 17;             // time of day width
  localparam int MIN_W    = 16;             // result width in minutes
  localparam int PROD_W   = CAP_W + TIME_W; // widest dividend, capacity times seconds
  localparam int DEN_W    = CAP_W + 6;      // widest divisor, capacity times sixty
  localparam int CNT_W    = $clog2(PROD_W + 1);
  localparam int MINUTE_S = 60;

  typedef struct packed {
    logic              cmd;
    logic [CAP_W-1:0]  cur_capacity;
    logic [CAP_W-1:0]  full_capacity;
    logic [CAP_W-1:0]  power_draw;
    logic              installed;
    logic              ac_online;
    logic              charging;
    logic [TIME_W-1:0] time_of_day;
  } brte_req_t;

  typedef struct packed {
    logic [MIN_W-1:0] minutes_left;
    logic             discharging;
  } brte_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } brte_state_t;

  // Command codes carried in the cmd field.
  localparam logic CMD_ESTIMATE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

endpackage

// ----- hdl/battery_remaining_time_estimator.sv -----
// Battery remaining-time estimator, top level.
// Uses brte_pkg for item types, widths and sequencer states.
//
// Usage: a battery reading arrives on req (valid/ready) and one result item
// leaves on rsp (valid/ready) for every reading accepted.
// The block works on one item at a time. After acceptance the setup state
// picks the case, forms the dividend with a single multiplier and updates
// the snapshot. A shared bit-serial restoring divider then takes one quotient
// bit per cycle for all PROD_W (41) dividend bits before the result is written
// to the output register. Readings that need no division skip the divider.
// An item passes from idle through setup, the divide state when needed, and
// done, where the result is loaded into the output register once it is free.
// req_ready is high only while the sequencer is idle. The finished result sits
// in the output register, so a new reading can be taken while it waits; if the
// receiver stalls, the next result waits in the done state until the output
// register is free.
// Reset is synchronous: the sequencer returns to idle, the output register is
// emptied and the capacity/time snapshot is cleared.
module battery_remaining_time_estimator
  import brte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  brte_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output brte_rsp_t rsp
);

  brte_state_t       state, state_next;
  brte_req_t         item;
  logic [CAP_W-1:0]  snap_cap;
  logic [TIME_W-1:0] snap_time;
  logic [PROD_W-1:0] num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;

  // Case decision for the captured item.
  logic              dis;
  logic              do_div;
  logic              snap_clear;
  logic              snap_take;
  logic [CAP_W-1:0]  mul_a;
  logic [TIME_W-1:0] mul_b;
  logic [PROD_W-1:0] product;
  logic [DEN_W-1:0]  den_sel;
  logic [CAP_W-1:0]  gone;
  logic [TIME_W-1:0] secs;
  logic [TIME_W:0]   snap_time_p1;
  logic [DEN_W:0]    trial;
  logic [MIN_W-1:0]  minutes;

  assign dis          = item.installed & ~item.ac_online & ~item.charging;
  assign gone         = snap_cap - item.cur_capacity;
  assign secs         = item.time_of_day - snap_time;
  assign snap_time_p1 = {1'b0, snap_time} + (TIME_W+1)'(1);

  always_comb begin
    do_div     = 1'b0;
    snap_clear = 1'b0;
    snap_take  = 1'b0;
    mul_a      = item.cur_capacity;
    mul_b      = TIME_W'(MINUTE_S);
    den_sel    = DEN_W'(item.power_draw);
    if (item.cmd == CMD_CLEAR) begin
      snap_clear = 1'b1;
    end else if (dis) begin
      if (item.cur_capacity != '0 && item.power_draw != '0) begin
        do_div = 1'b1;
      end else if (snap_cap == '0) begin
        snap_take = 1'b1;
      end else if ({1'b0, item.time_of_day} > snap_time_p1 &&
                   snap_cap > item.cur_capacity) begin
        // Extrapolate from the drop since the snapshot.
        do_div  = 1'b1;
        mul_b   = secs;
        den_sel = {gone, 6'b0} - {4'b0, gone, 2'b0};
      end
    end else begin
      snap_clear = 1'b1;
      if (item.charging && item.power_draw != '0 &&
          item.full_capacity > item.cur_capacity) begin
        do_div = 1'b1;
        mul_a  = item.full_capacity - item.cur_capacity;
      end
    end
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring division step: try to subtract the divisor.
  assign trial   = {rem, num[PROD_W-1]} - {1'b0, den};
  assign minutes = (num[PROD_W-1:MIN_W] != '0) ? {MIN_W{1'b1}} : num[MIN_W-1:0];

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = do_div ? ST_DIV : ST_DONE;
      ST_DIV:   if (cnt == CNT_W'(1)) state_next = ST_DONE;
      ST_DONE:  if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_cap  <= '0;
      snap_time <= '0;
    end else if (state == ST_SETUP) begin
      if (snap_clear) begin
        snap_cap <= '0;
      end else if (snap_take) begin
        snap_cap  <= item.cur_capacity;
        snap_time <= item.time_of_day;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) item <= req;
      end
      ST_SETUP: begin
        num <= do_div ? product : '0;
        den <= den_sel;
        rem <= '0;
        cnt <= CNT_W'(PROD_W);
      end
      ST_DIV: begin
        if (!trial[DEN_W]) begin
          rem <= trial[DEN_W-1:0];
        end else begin
          rem <= {rem[DEN_W-2:0], num[PROD_W-1]};
        end
        num <= {num[PROD_W-2:0], ~trial[DEN_W]};
        cnt <= cnt - CNT_W'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.minutes_left <= minutes;
      rsp.discharging  <= dis;
    end
  end

`ifndef SYNTHESIS
  a_div_count_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt != '0)
    else $error("divider running with an exhausted bit count");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < den)
    else $error("division remainder not below divisor");

  a_clear_snapshot: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP && (item.cmd == CMD_CLEAR || !dis) |=> snap_cap == '0)
    else $error("snapshot not cleared by a clearing item");

  a_done_to_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !rsp_valid |=> rsp_valid && state == ST_IDLE)
    else $error("finished item not moved to the output register");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for battery_remaining_time_estimator.
// Drives readings from a queue, predicts each estimate in a local model and checks results.
// Depends on hdl/brte_pkg.sv and hdl/battery_remaining_time_estimator.sv.
module tb
  import brte_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_RANDOM   = 950;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int          DRAIN_WAIT = 100;
  localparam int          IDLE_PCT   = 28;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  brte_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  brte_rsp_t rsp;

  brte_req_t readings_q[$];
  brte_rsp_t minutes_due[$];

  // Local copy of the forecast snapshot.
  logic [CAP_W-1:0]  snap_cap = '0;
  logic [TIME_W-1:0] snap_time = '0;

  int          n_total = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_err = 0;
  int          n_extrap = 0;
  int          n_sat = 0;
  int          n_clear = 0;
  int unsigned cycles = 0;
  bit          req_taken = 1'b0;

  battery_remaining_time_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic brte_rsp_t estimate_minutes(input brte_req_t r);
    logic [63:0] cur;
    logic [63:0] full;
    logic [63:0] pwr;
    logic [63:0] now;
    logic [63:0] q;
    logic        dis;
    brte_rsp_t   res;
    cur = 64'(r.cur_capacity);
    full = 64'(r.full_capacity);
    pwr = 64'(r.power_draw);
    now = 64'(r.time_of_day);
    q = '0;
    dis = r.installed && !r.ac_online && !r.charging;
    if (r.cmd == CMD_CLEAR) begin
      snap_cap = '0;
      n_clear++;
    end else if (dis) begin
      if (cur != 0 && pwr != 0) begin
        q = (cur * MINUTE_S) / pwr;
      end else if (snap_cap == '0) begin
        snap_time = r.time_of_day;
        snap_cap = r.cur_capacity;
      end else if (now > 64'(snap_time) + 1 && 64'(snap_cap) > cur) begin
        // Extrapolate from the capacity lost since the snapshot was taken.
        q = (cur * (now - 64'(snap_time))) / ((64'(snap_cap) - cur) * MINUTE_S);
        n_extrap++;
      end
    end else begin
      snap_cap = '0;
      if (r.charging && pwr != 0 && full > cur) begin
        q = ((full - cur) * MINUTE_S) / pwr;
      end
    end
    if (q > 64'hFFFF) begin
      n_sat++;
    end
    res.minutes_left = (q > 64'hFFFF) ? 16'hFFFF : q[MIN_W-1:0];
    res.discharging = dis;
    return res;
  endfunction

  function automatic void push_reading(input logic cmd, input int unsigned cur,
                                       input int unsigned full, input int unsigned pwr,
                                       input logic inst, input logic ac, input logic chg,
                                       input int unsigned tod);
    brte_req_t r;
    r.cmd = cmd;
    r.cur_capacity = cur[CAP_W-1:0];
    r.full_capacity = full[CAP_W-1:0];
    r.power_draw = pwr[CAP_W-1:0];
    r.installed = inst;
    r.ac_online = ac;
    r.charging = chg;
    r.time_of_day = tod[TIME_W-1:0];
    readings_q.push_back(r);
  endfunction

  // Random capacity with a random magnitude, so that quotients are not always saturated.
  function automatic int unsigned rnd_cap();
    int unsigned w;
    w = $urandom_range(1, CAP_W);
    return $urandom & ((32'h1 << w) - 1);
  endfunction

  // A forecast run: a snapshot reading followed by several further readings whose times mostly rise.
  task automatic add_forecast_run();
    int          cap;
    int          t;
    int          steps;
    int          drop;
    int unsigned pick;
    if ($urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1) begin
        push_reading(CMD_CLEAR, rnd_cap(), rnd_cap(), rnd_cap(), 1'b1, 1'b0, 1'b0,
                     $urandom_range(0, 86399));
      end else begin
        push_reading(CMD_ESTIMATE, rnd_cap(), rnd_cap(), rnd_cap(), 1'b1, 1'b1,
                     1'($urandom_range(0, 1)), $urandom_range(0, 86399));
      end
    end
    cap = ($urandom_range(0, 19) == 0) ? 0 : int'(rnd_cap());
    t = $urandom_range(0, 86399);
    push_reading(CMD_ESTIMATE, cap, rnd_cap(), 0, 1'b1, 1'b0, 1'b0, t);
    steps = $urandom_range(2, 6);
    repeat (steps) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: t = t - int'($urandom_range(1, 500));
        1: t = t + int'($urandom_range(0, 1));
        2: t = t + int'($urandom_range(2, 40000));
        default: t = t + int'($urandom_range(2, 3600));
      endcase
      if (t < 0) begin
        t = 0;
      end else if (t > 131071) begin
        t = 131071;
      end
      if ($urandom_range(0, 9) == 0) begin
        cap = cap + int'($urandom_range(0, 3));
        if (cap > 16777215) begin
          cap = 16777215;
        end
      end else if (cap > 0) begin
        drop = $urandom_range(1, (cap >> ($urandom_range(0, 6))) + 1);
        cap = (drop > cap) ? 0 : cap - drop;
      end
      push_reading(CMD_ESTIMATE, cap, rnd_cap(), 0, 1'b1, 1'b0, 1'b0, t);
    end
  endtask

  task automatic add_random_part();
    int          target;
    int unsigned pick;
    int unsigned cur;
    target = readings_q.size() + N_RANDOM;
    while (readings_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add_forecast_run();
      end else if (pick < 65) begin
        push_reading(CMD_ESTIMATE, rnd_cap(), rnd_cap(), rnd_cap(), 1'b1, 1'b0, 1'b0,
                     $urandom_range(0, 86399));
      end else if (pick < 80) begin
        cur = rnd_cap();
        push_reading(CMD_ESTIMATE, cur, ($urandom_range(0, 3) == 0) ? cur : rnd_cap(),
                     ($urandom_range(0, 7) == 0) ? 0 : rnd_cap(),
                     $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)), 1'b1,
                     $urandom_range(0, 86399));
      end else if (pick < 90) begin
        push_reading(CMD_CLEAR, rnd_cap(), rnd_cap(), rnd_cap(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 86399));
      end else begin
        // Unshaped noise over the whole width of every field.
        push_reading(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  // Sender: present the next reading once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      req_taken = 1'b0;
      if (readings_q.size() != 0 &&
          ((n_sent >= 300 && n_sent < 450) || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req <= readings_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      minutes_due.push_back(estimate_minutes(req));
      n_sent++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= (n_got >= 300 && n_got < 450) || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    brte_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_got++;
      if (minutes_due.size() == 0) begin
        $display("%0t: result with nothing expected: minutes %0d discharging %0b",
                 $time, rsp.minutes_left, rsp.discharging);
        n_err++;
      end else begin
        want = minutes_due.pop_front();
        if (rsp.minutes_left !== want.minutes_left) begin
          $display("%0t: minutes_left expected %0d actual %0d",
                   $time, want.minutes_left, rsp.minutes_left);
          n_err++;
        end
        if (rsp.discharging !== want.discharging) begin
          $display("%0t: discharging expected %0b actual %0b",
                   $time, want.discharging, rsp.discharging);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timed out with %0d of %0d items sent, %0d results pending",
               $time, n_sent, n_total, minutes_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Directed readings: extremes, every case of the estimator and each corner.
    push_reading(CMD_ESTIMATE, 24'hFFFFFF, 0, 1, 1'b1, 1'b0, 1'b0, 0);
    push_reading(CMD_ESTIMATE, 1000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 86399);
    push_reading(CMD_ESTIMATE, 0, 500, 5, 1'b1, 1'b0, 1'b0, 10);
    // A snapshot taken at zero capacity does not count, so this one takes a new one.
    push_reading(CMD_ESTIMATE, 5000, 9000, 0, 1'b1, 1'b0, 1'b0, 100);
    push_reading(CMD_ESTIMATE, 5000, 9000, 0, 1'b1, 1'b0, 1'b0, 200);
    push_reading(CMD_ESTIMATE, 4000, 9000, 0, 1'b1, 1'b0, 1'b0, 101);
    push_reading(CMD_ESTIMATE, 4000, 9000, 0, 1'b1, 1'b0, 1'b0, 50);
    push_reading(CMD_ESTIMATE, 4000, 9000, 0, 1'b1, 1'b0, 1'b0, 700);
    push_reading(CMD_ESTIMATE, 0, 9000, 0, 1'b1, 1'b0, 1'b0, 900);
    push_reading(CMD_CLEAR, 3000, 9000, 0, 1'b1, 1'b0, 1'b0, 1000);
    push_reading(CMD_ESTIMATE, 24'hFFFFFF, 0, 0, 1'b1, 1'b0, 1'b0, 0);
    push_reading(CMD_ESTIMATE, 24'hFFFFFE, 0, 0, 1'b1, 1'b0, 1'b0, 131071);
    push_reading(CMD_ESTIMATE, 0, 24'hFFFFFF, 1, 1'b1, 1'b1, 1'b1, 500);
    push_reading(CMD_ESTIMATE, 700, 700, 10, 1'b1, 1'b1, 1'b1, 500);
    push_reading(CMD_ESTIMATE, 700, 600, 10, 1'b1, 1'b0, 1'b1, 500);
    push_reading(CMD_ESTIMATE, 100, 9000, 0, 1'b1, 1'b1, 1'b1, 500);
    push_reading(CMD_ESTIMATE, 100, 9000, 77, 1'b0, 1'b0, 1'b1, 500);
    push_reading(CMD_ESTIMATE, 100, 9000, 77, 1'b0, 1'b0, 1'b0, 500);
    push_reading(CMD_ESTIMATE, 100, 9000, 77, 1'b1, 1'b1, 1'b0, 500);
    push_reading(CMD_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 131071);
    push_reading(CMD_ESTIMATE, 0, 0, 0, 1'b1, 1'b0, 1'b0, 0);
    push_reading(CMD_ESTIMATE, 0, 0, 0, 1'b0, 1'b0, 1'b0, 0);
    add_random_part();
    n_total = readings_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (n_sent < n_total) @(posedge clk);
    while (minutes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d readings and checked %0d results in %0d cycles.",
             n_sent, n_got, cycles);
    $display("Covered %0d extrapolated forecasts, %0d saturated estimates, %0d clears.",
             n_extrap, n_sat, n_clear);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
